// File: hdl/tgr_pkg.sv
// ----------------------------------------------------------------------------
// tgr_pkg: shared types and constants of the tick-to-grid resampler
// Word layouts, result kinds, register indexes and datapath command codes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package tgr_pkg;

    localparam int DAY_W       = 16;
    localparam int SEC_W       = 17;
    localparam int SLOT_W      = 18;
    localparam int OUT_PRICE_W = 48;
    localparam int KIND_W      = 2;
    localparam int PRICE_W     = 48;
    localparam int CFG_IDX_W   = 2;
    localparam int MUL_STEPS   = SLOT_W;

    // register reset values
    localparam logic [SEC_W-1:0] INTERVAL_RST = 17'd300;
    localparam logic [SEC_W-1:0] OPEN_RST     = 17'd34200;
    localparam logic [SEC_W-1:0] CLOSE_RST    = 17'd57600;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_INTERVAL = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OPEN     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CLOSE    = 2'd2;

    // result kinds
    localparam logic [KIND_W-1:0] KIND_EXACT = 2'd0;
    localparam logic [KIND_W-1:0] KIND_MIX   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_CARRY = 2'd2;
    localparam logic [KIND_W-1:0] KIND_RUN   = 2'd3;

    // datapath commands
    localparam int CMD_W = 4;
    localparam logic [CMD_W-1:0] CMD_NONE      = 4'd0;
    localparam logic [CMD_W-1:0] CMD_CAPTURE   = 4'd1;
    localparam logic [CMD_W-1:0] CMD_NEWDAY    = 4'd2;
    localparam logic [CMD_W-1:0] CMD_EXACT     = 4'd3;
    localparam logic [CMD_W-1:0] CMD_KEEP      = 4'd4;
    localparam logic [CMD_W-1:0] CMD_CARRY     = 4'd5;
    localparam logic [CMD_W-1:0] CMD_RUN_DIV   = 4'd6;
    localparam logic [CMD_W-1:0] CMD_RUN       = 4'd7;
    localparam logic [CMD_W-1:0] CMD_MIX_START = 4'd8;
    localparam logic [CMD_W-1:0] CMD_MIX_DIV   = 4'd9;
    localparam logic [CMD_W-1:0] CMD_MIX_OUT   = 4'd10;
    localparam logic [CMD_W-1:0] CMD_MIX_ZERO  = 4'd11;

    typedef struct packed {
        logic [DAY_W-1:0]   day_number;
        logic [SEC_W-1:0]   tick_seconds;
        logic [OUT_PRICE_W-1:0] tick_price;
    } t_in_word;

    typedef struct packed {
        logic [DAY_W-1:0]       slot_day;
        logic [SEC_W-1:0]       slot_seconds;
        logic [OUT_PRICE_W-1:0] slot_price;
        logic [KIND_W-1:0]      result_kind;
        logic [SEC_W-1:0]       na_count;
        logic                   last_of_run;
    } t_out_word;

    typedef struct packed {
        logic [CMD_W-1:0] op;
        logic             run_last;
    } t_dp_cmd;

    typedef struct packed {
        logic new_day;
        logic in_window;
        logic on_slot;
        logic below_slot;
        logic after_last;
        logic after_close;
        logic day_done;
        logic slot_ok;
        logic at_open;
        logic s_zero;
        logic mul_busy;
        logic div_busy;
        logic out_free;
    } t_dp_stat;

endpackage

// File: hdl/tgr_div.sv
// ----------------------------------------------------------------------------
// tgr_div: iterative restoring divider
// One quotient bit per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tgr_div #(
    parameter int NUM_W = 67,
    parameter int DEN_W = 18
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    output logic             o_busy,
    output logic [NUM_W-1:0] o_quo,
    output logic [DEN_W-1:0] o_rem
);
    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [NUM_W-1:0] r_quo;
    logic [DEN_W-1:0] r_rem, r_den;
    logic [CNT_W-1:0] r_cnt;
    logic [DEN_W:0]   rem_sh;
    logic             fits;

    // trial subtract of the shifted remainder
    assign rem_sh = {r_rem, r_quo[NUM_W-1]};
    assign fits   = rem_sh >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_start) begin
            r_cnt <= CNT_W'(NUM_W);
        end else if (r_cnt != '0) begin
            r_cnt <= r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_num;
            r_rem <= '0;
            r_den <= i_den;
        end else if (r_cnt != '0) begin
            r_quo <= {r_quo[NUM_W-2:0], fits};
            r_rem <= fits ? DEN_W'(rem_sh - {1'b0, r_den}) : rem_sh[DEN_W-1:0];
        end
    end

    assign o_busy = r_cnt != '0;
    assign o_quo  = r_quo;
    assign o_rem  = r_rem;

endmodule

// File: hdl/tgr_dp.sv
// ----------------------------------------------------------------------------
// tgr_dp: resampler datapath
// Session state, registers, serial multiplier, shared divider, output word.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tgr_dp #(
    parameter int PRICE_WIDTH = tgr_pkg::PRICE_W
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  tgr_pkg::t_in_word               i_in_data,
    input  logic                            i_cfg_valid,
    input  logic [tgr_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [tgr_pkg::SEC_W-1:0]       i_cfg_data,
    output logic                            o_cfg_ready,
    input  logic                            i_out_ready,
    output logic                            o_out_valid,
    output tgr_pkg::t_out_word              o_out_data,
    input  tgr_pkg::t_dp_cmd                i_cmd,
    output tgr_pkg::t_dp_stat               o_stat
);
    import tgr_pkg::*;

    localparam int ACC_W = PRICE_WIDTH + SLOT_W;
    localparam int NUM_W = PRICE_WIDTH + SLOT_W + 1;
    localparam int MC_W  = $clog2(MUL_STEPS + 1);

    // configuration
    logic [SEC_W-1:0] r_interval, r_open, r_close;
    // session state
    logic [DAY_W-1:0]       r_cur_day;
    logic                   r_seen, r_done;
    logic [SLOT_W-1:0]      r_next;
    logic [SEC_W-1:0]       r_last_t;
    logic [PRICE_WIDTH-1:0] r_last_p;
    // captured word
    logic [DAY_W-1:0]       r_day;
    logic [SEC_W-1:0]       r_t;
    logic [PRICE_WIDTH-1:0] r_p;
    // multiplier
    logic [SLOT_W-1:0]      r_ma, r_mb;
    logic [ACC_W-1:0]       r_acc_a, r_acc_b;
    logic [MC_W-1:0]        r_mcnt;
    logic                   r_a_neg, r_neg;
    // output
    logic                   r_out_valid;
    t_out_word              r_out;

    logic [SEC_W-1:0]       iv_eff;
    logic [SLOT_W-1:0]      t_ext, close_ext, next_iv, a_mag, b_mag, s_mag, run_num;
    logic                   a_neg, s_neg, out_free, cmp_gt;
    logic [NUM_W-1:0]       mix_num, div_num, quo;
    logic [SLOT_W-1:0]      div_den, rem;
    logic                   div_start, div_busy, mix_neg;
    logic [PRICE_WIDTH-1:0] mix_price;
    logic [SLOT_W:0]        run_next;
    logic [SLOT_W-1:0]      cnt_p1;
    logic [SEC_W-1:0]       run_cnt;

    assign iv_eff    = (r_interval == '0) ? SEC_W'(1) : r_interval;
    assign t_ext     = {1'b0, r_t};
    assign close_ext = {1'b0, r_close};
    assign next_iv   = r_next + {1'b0, iv_eff};

    // slot and tick distances
    assign a_neg = r_next < {1'b0, r_last_t};
    assign a_mag = a_neg ? ({1'b0, r_last_t} - r_next) : (r_next - {1'b0, r_last_t});
    assign b_mag = t_ext - r_next;
    assign s_neg = r_t < r_last_t;
    assign s_mag = s_neg ? {1'b0, r_last_t - r_t} : {1'b0, r_t - r_last_t};

    // numerator of the mix from the two products
    assign cmp_gt = r_acc_a > r_acc_b;
    always_comb begin
        if (!r_a_neg) begin
            mix_num = {1'b0, r_acc_a} + {1'b0, r_acc_b};
            mix_neg = 1'b0;
        end else if (cmp_gt) begin
            mix_num = {1'b0, r_acc_a - r_acc_b};
            mix_neg = 1'b1;
        end else begin
            mix_num = {1'b0, r_acc_b - r_acc_a};
            mix_neg = 1'b0;
        end
    end

    assign run_num   = close_ext - r_next;
    assign div_start = (i_cmd.op == CMD_RUN_DIV) || (i_cmd.op == CMD_MIX_DIV);
    assign div_num   = (i_cmd.op == CMD_MIX_DIV) ? mix_num : NUM_W'(run_num);
    assign div_den   = (i_cmd.op == CMD_MIX_DIV) ? s_mag : {1'b0, iv_eff};

    tgr_div #(
        .NUM_W (NUM_W),
        .DEN_W (SLOT_W)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_busy  (div_busy),
        .o_quo   (quo),
        .o_rem   (rem)
    );

    // saturate the mix quotient to the price range
    always_comb begin
        if (quo == '0 || r_neg) begin
            mix_price = '0;
        end else if (quo[NUM_W-1:PRICE_WIDTH] != '0) begin
            mix_price = '1;
        end else begin
            mix_price = quo[PRICE_WIDTH-1:0];
        end
    end

    // run count and the slot after the run
    assign cnt_p1   = quo[SLOT_W-1:0] + 1'b1;
    assign run_cnt  = cnt_p1[SEC_W] ? '1 : cnt_p1[SEC_W-1:0];
    assign run_next = {1'b0, close_ext} - {1'b0, rem} + {2'b0, iv_eff};

    assign out_free = !r_out_valid || i_out_ready;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_interval <= INTERVAL_RST;
            r_open     <= OPEN_RST;
            r_close    <= CLOSE_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_INTERVAL: r_interval <= i_cfg_data;
                CFG_OPEN:     r_open     <= i_cfg_data;
                CFG_CLOSE:    r_close    <= i_cfg_data;
                default:      ;
            endcase
        end
    end

    // session state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_day <= '0;
            r_seen    <= 1'b0;
            r_done    <= 1'b1;
            r_next    <= '0;
            r_last_t  <= '0;
            r_last_p  <= '0;
        end else begin
            case (i_cmd.op)
                CMD_NEWDAY: begin
                    r_cur_day <= r_day;
                    r_seen    <= 1'b1;
                    if (r_t >= r_open) begin
                        r_next   <= {1'b0, r_open} + {1'b0, iv_eff};
                        r_last_t <= r_t;
                        r_last_p <= r_p;
                        r_done   <= 1'b0;
                    end else begin
                        r_next <= {1'b0, r_open};
                    end
                end
                CMD_EXACT, CMD_MIX_OUT, CMD_MIX_ZERO: begin
                    r_next   <= next_iv;
                    r_last_t <= r_t;
                    r_last_p <= r_p;
                end
                CMD_KEEP: begin
                    r_last_t <= r_t;
                    r_last_p <= r_p;
                end
                CMD_CARRY: r_next <= next_iv;
                CMD_RUN: begin
                    r_done <= 1'b1;
                    if (r_next <= close_ext) begin
                        r_next <= run_next[SLOT_W-1:0];
                    end
                end
                default: ;
            endcase
        end
    end

    // captured word
    always_ff @(posedge i_clk) begin
        if (i_cmd.op == CMD_CAPTURE) begin
            r_day <= i_in_data.day_number;
            r_t   <= i_in_data.tick_seconds;
            r_p   <= PRICE_WIDTH'(i_in_data.tick_price);
        end
    end

    // serial multiplier, MSB first, both products at once
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mcnt <= '0;
        end else if (i_cmd.op == CMD_MIX_START) begin
            r_mcnt <= MC_W'(MUL_STEPS);
        end else if (r_mcnt != '0) begin
            r_mcnt <= r_mcnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.op == CMD_MIX_START) begin
            r_ma    <= a_mag;
            r_mb    <= b_mag;
            r_a_neg <= a_neg;
            r_acc_a <= '0;
            r_acc_b <= '0;
        end else if (r_mcnt != '0) begin
            r_ma    <= {r_ma[SLOT_W-2:0], 1'b0};
            r_mb    <= {r_mb[SLOT_W-2:0], 1'b0};
            r_acc_a <= {r_acc_a[ACC_W-2:0], 1'b0}
                       + (r_ma[SLOT_W-1] ? ACC_W'(r_last_p) : '0);
            r_acc_b <= {r_acc_b[ACC_W-2:0], 1'b0}
                       + (r_mb[SLOT_W-1] ? ACC_W'(r_p) : '0);
        end
        if (i_cmd.op == CMD_MIX_DIV) begin
            r_neg <= mix_neg ^ s_neg;
        end
    end

    // output word register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if ((i_cmd.op == CMD_NEWDAY && r_t >= r_open)
                     || i_cmd.op == CMD_EXACT || i_cmd.op == CMD_CARRY
                     || i_cmd.op == CMD_RUN || i_cmd.op == CMD_MIX_OUT
                     || i_cmd.op == CMD_MIX_ZERO) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            CMD_NEWDAY: begin
                r_out.slot_day     <= r_day;
                r_out.slot_seconds <= r_open;
                r_out.slot_price   <= OUT_PRICE_W'(r_p);
                r_out.result_kind  <= KIND_EXACT;
                r_out.na_count     <= '0;
                r_out.last_of_run  <= 1'b1;
            end
            CMD_EXACT: begin
                r_out.slot_day     <= r_cur_day;
                r_out.slot_seconds <= r_t;
                r_out.slot_price   <= OUT_PRICE_W'(r_p);
                r_out.result_kind  <= KIND_EXACT;
                r_out.na_count     <= '0;
                r_out.last_of_run  <= 1'b1;
            end
            CMD_CARRY: begin
                r_out.slot_day     <= r_cur_day;
                r_out.slot_seconds <= r_next[SEC_W-1:0];
                r_out.slot_price   <= OUT_PRICE_W'(r_last_p);
                r_out.result_kind  <= KIND_CARRY;
                r_out.na_count     <= '0;
                r_out.last_of_run  <= 1'b0;
            end
            CMD_RUN: begin
                r_out.slot_day     <= r_cur_day;
                r_out.slot_price   <= '0;
                r_out.result_kind  <= KIND_RUN;
                r_out.last_of_run  <= i_cmd.run_last;
                if (r_next <= close_ext) begin
                    r_out.slot_seconds <= r_next[SEC_W-1:0];
                    r_out.na_count     <= run_cnt;
                end else begin
                    r_out.slot_seconds <= '0;
                    r_out.na_count     <= '0;
                end
            end
            CMD_MIX_OUT, CMD_MIX_ZERO: begin
                r_out.slot_day     <= r_cur_day;
                r_out.slot_seconds <= r_next[SEC_W-1:0];
                r_out.slot_price   <= (i_cmd.op == CMD_MIX_OUT) ?
                                      OUT_PRICE_W'(mix_price) : OUT_PRICE_W'(r_last_p);
                r_out.result_kind  <= KIND_MIX;
                r_out.na_count     <= '0;
                r_out.last_of_run  <= 1'b1;
            end
            default: ;
        endcase
    end

    // status to the controller
    assign o_stat.new_day     = !r_seen || (r_day != r_cur_day);
    assign o_stat.in_window   = (r_t <= r_close) && (r_t > r_open);
    assign o_stat.on_slot     = t_ext == r_next;
    assign o_stat.below_slot  = t_ext < r_next;
    assign o_stat.after_last  = r_t > r_last_t;
    assign o_stat.after_close = r_t > r_close;
    assign o_stat.day_done    = r_done;
    assign o_stat.slot_ok     = r_next <= close_ext;
    assign o_stat.at_open     = r_t >= r_open;
    assign o_stat.s_zero      = r_t == r_last_t;
    assign o_stat.mul_busy    = r_mcnt != '0;
    assign o_stat.div_busy    = div_busy;
    assign o_stat.out_free    = out_free;

    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

// File: hdl/tgr_ctrl.sv
// ----------------------------------------------------------------------------
// tgr_ctrl: resampler controller
// Classifies each word and sequences the datapath through its results.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tgr_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  tgr_pkg::t_dp_stat i_stat,
    output tgr_pkg::t_dp_cmd  o_cmd
);
    import tgr_pkg::*;

    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_DECIDE  = 4'd1;
    localparam logic [3:0] S_CARRY   = 4'd2;
    localparam logic [3:0] S_RUNCHK  = 4'd3;
    localparam logic [3:0] S_RUNDIV  = 4'd4;
    localparam logic [3:0] S_RUN     = 4'd5;
    localparam logic [3:0] S_NEWDAY  = 4'd6;
    localparam logic [3:0] S_EXACT   = 4'd7;
    localparam logic [3:0] S_MIXZ    = 4'd8;
    localparam logic [3:0] S_MUL     = 4'd9;
    localparam logic [3:0] S_MIXDIV  = 4'd10;
    localparam logic [3:0] S_MIXOUT  = 4'd11;

    logic [3:0] r_state, n_state;
    logic       r_newday, n_newday;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_newday <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_newday <= n_newday;
        end
    end

    // next state and command
    always_comb begin
        n_state      = r_state;
        n_newday     = r_newday;
        o_cmd.op     = CMD_NONE;
        o_cmd.run_last = !(r_newday && i_stat.at_open);
        o_in_ready   = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.op = CMD_CAPTURE;
                    n_state  = S_DECIDE;
                end
            end
            S_DECIDE: begin
                if (i_stat.new_day) begin
                    n_newday = 1'b1;
                    n_state  = i_stat.day_done ? S_NEWDAY : S_CARRY;
                end else if (i_stat.in_window) begin
                    if (i_stat.on_slot) begin
                        n_state = S_EXACT;
                    end else if (i_stat.below_slot) begin
                        if (i_stat.after_last) begin
                            o_cmd.op = CMD_KEEP;
                        end
                        n_state = S_IDLE;
                    end else if (i_stat.s_zero) begin
                        n_state = S_MIXZ;
                    end else begin
                        o_cmd.op = CMD_MIX_START;
                        n_state  = S_MUL;
                    end
                end else if (i_stat.after_close && !i_stat.day_done) begin
                    n_newday = 1'b0;
                    n_state  = S_CARRY;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_CARRY: begin
                if (!i_stat.slot_ok) begin
                    n_state = S_RUNCHK;
                end else if (i_stat.out_free) begin
                    o_cmd.op = CMD_CARRY;
                    n_state  = S_RUNCHK;
                end
            end
            S_RUNCHK: begin
                if (i_stat.slot_ok) begin
                    o_cmd.op = CMD_RUN_DIV;
                    n_state  = S_RUNDIV;
                end else begin
                    n_state = S_RUN;
                end
            end
            S_RUNDIV: begin
                if (!i_stat.div_busy) begin
                    n_state = S_RUN;
                end
            end
            S_RUN: begin
                if (i_stat.out_free) begin
                    o_cmd.op = CMD_RUN;
                    n_state  = r_newday ? S_NEWDAY : S_IDLE;
                end
            end
            S_NEWDAY: begin
                if (i_stat.out_free) begin
                    o_cmd.op = CMD_NEWDAY;
                    n_state  = S_IDLE;
                end
            end
            S_EXACT: begin
                if (i_stat.out_free) begin
                    o_cmd.op = CMD_EXACT;
                    n_state  = S_IDLE;
                end
            end
            S_MIXZ: begin
                if (i_stat.out_free) begin
                    o_cmd.op = CMD_MIX_ZERO;
                    n_state  = S_IDLE;
                end
            end
            S_MUL: begin
                if (!i_stat.mul_busy) begin
                    o_cmd.op = CMD_MIX_DIV;
                    n_state  = S_MIXDIV;
                end
            end
            S_MIXDIV: begin
                if (!i_stat.div_busy) begin
                    n_state = S_MIXOUT;
                end
            end
            S_MIXOUT: begin
                if (i_stat.out_free) begin
                    o_cmd.op = CMD_MIX_OUT;
                    n_state  = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

endmodule

// File: hdl/tick_to_grid_resampler.sv
// ----------------------------------------------------------------------------
// tick_to_grid_resampler: price ticks to a regular intraday time grid
// Emits exact, weighted-mix, carried and not-available-run results per tick.
// ----------------------------------------------------------------------------
//  channel | direction | handshake                  | word
//  in      | input     | i_in_valid / o_in_ready    | t_in_word
//  out     | output    | o_out_valid / i_out_ready  | t_out_word
//  cfg     | input     | i_cfg_valid / o_cfg_ready  | index + 17-bit data
//
//  One word at a time. A weighted mix runs 18 serial multiply steps and
//  then PRICE_WIDTH + 19 divider steps; a day close adds a slot-count
//  division. Reset is synchronous; there is no clearing pass. A stalled
//  output holds the controller at its next result; cfg is always ready.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tick_to_grid_resampler #(
    parameter int PRICE_WIDTH = tgr_pkg::PRICE_W
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  tgr_pkg::t_in_word             i_in_data,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output tgr_pkg::t_out_word            o_out_data,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [tgr_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [tgr_pkg::SEC_W-1:0]     i_cfg_data
);
    import tgr_pkg::*;

    t_dp_cmd  cmd;
    t_dp_stat stat;

    tgr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    tgr_dp #(
        .PRICE_WIDTH (PRICE_WIDTH)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_data   (i_in_data),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg_ready (o_cfg_ready),
        .i_out_ready (i_out_ready),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data),
        .i_cmd       (cmd),
        .o_stat      (stat)
    );

endmodule

// File: hdl/tgr_chk.sv
// ----------------------------------------------------------------------------
// tgr_chk: port-level checks of the resampler
// Output channel rules and result word consistency.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tgr_chk (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_in_valid,
    input logic                          o_in_ready,
    input tgr_pkg::t_in_word             i_in_data,
    input logic                          o_out_valid,
    input logic                          i_out_ready,
    input tgr_pkg::t_out_word            o_out_data,
    input logic                          i_cfg_valid,
    input logic                          o_cfg_ready,
    input logic [tgr_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input logic [tgr_pkg::SEC_W-1:0]     i_cfg_data
);
    import tgr_pkg::*;

    // stalled word stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rst_n && o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("output word dropped while stalled");

    // stalled word unchanged
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rst_n && o_out_valid && !i_out_ready |=> $stable(o_out_data))
        else $error("output word changed while stalled");

    // a run result carries no price
    a_run_price: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.result_kind == KIND_RUN
        |-> o_out_data.slot_price == '0)
        else $error("run result with nonzero price");

    // only run results count slots
    a_count_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.na_count != '0
        |-> o_out_data.result_kind == KIND_RUN)
        else $error("slot count on a priced result");

    // a carried price is always followed by its run result
    a_carry_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.result_kind == KIND_CARRY
        |-> !o_out_data.last_of_run)
        else $error("carried price marked last");

endmodule

bind tick_to_grid_resampler tgr_chk u_chk (.*);

// File: bench/tb_tick_to_grid_resampler.sv
// ----------------------------------------------------------------------------
// tb_tick_to_grid_resampler: self-checking bench of the tick-to-grid resampler
// Drives price ticks through valid/ready with random idle bursts, predicts every
// output word from a local model of the grid state, and checks the words in order
// over several register settings, the extremes among them.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_tick_to_grid_resampler;
    import tgr_pkg::*;

    localparam int PW = PRICE_W;
    localparam logic [47:0] PMAX = {PW{1'b1}};
    localparam int SETTLE = 400;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_in_valid = 1'b0;
    logic o_in_ready;
    t_in_word i_in_data = '0;
    logic o_out_valid;
    logic i_out_ready = 1'b0;
    t_out_word o_out_data;
    logic i_cfg_valid = 1'b0;
    logic o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [SEC_W-1:0] i_cfg_data = '0;

    tick_to_grid_resampler u_dut (.*);

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // grid state of the predictor
    logic [16:0] iv_reg, open_reg, close_reg;
    logic [15:0] cur_day;
    logic        day_seen, day_done;
    logic [17:0] next_slot;
    logic [16:0] last_tick;
    logic [47:0] last_px;

    t_in_word  tick_q[$];
    t_out_word grid_q[$];
    int  n_fail = 0, n_words = 0, n_ticks = 0;
    bit  quiet = 1'b0;

    function automatic logic [47:0] mix_px(logic [17:0] slot, logic [16:0] t,
                                           logic [47:0] p);
        longint a, b, s;
        logic [127:0] ta, tb, num, q;
        bit neg;
        a = longint'(slot) - longint'(last_tick);
        b = longint'(t) - longint'(slot);
        s = longint'(t) - longint'(last_tick);
        if (s == 0) return last_px;
        ta = 128'(last_px) * 128'(a < 0 ? -a : a);
        tb = 128'(p) * 128'(b);
        neg = 1'b0;
        if (a >= 0) num = ta + tb;
        else if (ta > tb) begin num = ta - tb; neg = 1'b1; end
        else num = tb - ta;
        q = num / 128'(s < 0 ? -s : s);
        if (s < 0) neg = !neg;
        if (q == 0 || neg) return '0;
        if (q > 128'(PMAX)) return PMAX;
        return q[47:0];
    endfunction

    function automatic void push_word(logic [15:0] d, logic [16:0] sec, logic [47:0] px,
                                      logic [1:0] kind, logic [16:0] cnt);
        t_out_word w;
        w.slot_day = d; w.slot_seconds = sec; w.slot_price = px & PMAX;
        w.result_kind = kind; w.na_count = cnt; w.last_of_run = 1'b0;
        grid_q.push_back(w);
    endfunction

    function automatic void close_day_words();
        logic [16:0] iv, first;
        longint cnt;
        iv = (iv_reg == 0) ? 17'd1 : iv_reg;
        first = '0; cnt = 0;
        if (day_done) return;
        if (next_slot <= close_reg) begin
            push_word(cur_day, next_slot[16:0], last_px, KIND_CARRY, '0);
            next_slot = next_slot + iv;
        end
        if (next_slot <= close_reg) begin
            first = next_slot[16:0];
            cnt = (close_reg - next_slot) / iv + 1;
            next_slot = 18'(next_slot + cnt * iv);
            if (cnt > 131071) cnt = 131071;
        end
        push_word(cur_day, first, '0, KIND_RUN, 17'(cnt));
        day_done = 1'b1;
    endfunction

    function automatic void predict_tick(t_in_word w);
        logic [16:0] t, iv;
        logic [47:0] p;
        int n0;
        t = w.tick_seconds; p = w.tick_price & PMAX;
        iv = (iv_reg == 0) ? 17'd1 : iv_reg;
        n0 = grid_q.size();
        if (!day_seen || w.day_number != cur_day) begin
            close_day_words();
            cur_day = w.day_number; day_seen = 1'b1; next_slot = open_reg;
            if (t >= open_reg) begin
                push_word(cur_day, open_reg, p, KIND_EXACT, '0);
                last_tick = t; last_px = p; next_slot = next_slot + iv;
                day_done = 1'b0;
            end
        end else if (t <= close_reg && t > open_reg) begin
            if (t == next_slot) begin
                push_word(cur_day, t, p, KIND_EXACT, '0);
                last_tick = t; last_px = p; next_slot = next_slot + iv;
            end else if (t < next_slot) begin
                if (t > last_tick) begin last_tick = t; last_px = p; end
            end else begin
                push_word(cur_day, next_slot[16:0], mix_px(next_slot, t, p), KIND_MIX, '0);
                last_tick = t; last_px = p; next_slot = next_slot + iv;
            end
        end else if (t > close_reg && !day_done) begin
            close_day_words();
        end
        if (grid_q.size() > n0) grid_q[grid_q.size()-1].last_of_run = 1'b1;
    endfunction

    // driver: next pending tick, with random idle bursts
    int in_idle = 0;
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && o_in_ready) begin
                predict_tick(i_in_data);
                n_ticks++;
            end
            if (!i_in_valid || o_in_ready) begin
                if (in_idle > 0) begin
                    in_idle--;
                    i_in_valid <= 1'b0;
                end else if (tick_q.size() > 0) begin
                    i_in_valid <= 1'b1;
                    i_in_data <= tick_q.pop_front();
                    if (!quiet && $urandom_range(0, 5) == 0) in_idle = $urandom_range(1, 17);
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // monitor: compare each output word with the oldest expectation
    int out_idle = 0;
    always @(posedge i_clk) begin
        t_out_word e;
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready) begin
                n_words++;
                if (grid_q.size() == 0) begin
                    $error("unexpected word %p", o_out_data);
                    n_fail++;
                end else begin
                    e = grid_q.pop_front();
                    if (o_out_data.slot_day !== e.slot_day) begin
                        $error("slot_day exp %0d got %0d", e.slot_day, o_out_data.slot_day);
                        n_fail++;
                    end
                    if (o_out_data.slot_seconds !== e.slot_seconds) begin
                        $error("slot_seconds exp %0d got %0d", e.slot_seconds,
                               o_out_data.slot_seconds);
                        n_fail++;
                    end
                    if (o_out_data.slot_price !== e.slot_price) begin
                        $error("slot_price exp %0h got %0h", e.slot_price,
                               o_out_data.slot_price);
                        n_fail++;
                    end
                    if (o_out_data.result_kind !== e.result_kind) begin
                        $error("result_kind exp %0d got %0d", e.result_kind,
                               o_out_data.result_kind);
                        n_fail++;
                    end
                    if (o_out_data.na_count !== e.na_count) begin
                        $error("na_count exp %0d got %0d", e.na_count, o_out_data.na_count);
                        n_fail++;
                    end
                    if (o_out_data.last_of_run !== e.last_of_run) begin
                        $error("last_of_run exp %0b got %0b", e.last_of_run,
                               o_out_data.last_of_run);
                        n_fail++;
                    end
                end
            end
            if (out_idle > 0) begin
                out_idle--;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= 1'b1;
                if (!quiet && $urandom_range(0, 4) == 0) out_idle = $urandom_range(1, 17);
            end
        end
    end

    task automatic wait_drained();
        while (tick_q.size() > 0 || i_in_valid || grid_q.size() > 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    // one register write, then valid is lowered on the cfg channel before the task returns
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [16:0] val);
        i_cfg_valid <= 1'b1; i_cfg_index <= idx; i_cfg_data <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        if (idx == CFG_INTERVAL) iv_reg = val;
        else if (idx == CFG_OPEN) open_reg = val;
        else close_reg = val;
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    function automatic void add_tick(logic [15:0] d, logic [16:0] t, logic [47:0] p);
        t_in_word w;
        w.day_number = d; w.tick_seconds = t; w.tick_price = p;
        tick_q.push_back(w);
    endfunction

    function automatic logic [47:0] rnd_px();
        case ($urandom_range(0, 5))
            0: return '0;
            1: return PMAX;
            2: return 48'({$urandom(), $urandom()});
            default: return 48'($urandom_range(0, 32'hFFFF_FFFF)) >> $urandom_range(0, 20);
        endcase
    endfunction

    function automatic int next_slot_guess(int t);
        int iv;
        iv = (iv_reg == 0) ? 1 : iv_reg;
        if (t < open_reg) return open_reg;
        return open_reg + ((t - open_reg) / iv + 1) * iv;
    endfunction

    // one session: well-formed ascending ticks of one day, some noise
    function automatic void add_day(logic [15:0] d, int n);
        int t;
        t = open_reg - $urandom_range(0, 2) * $urandom_range(0, 60);
        if (t < 0) t = 0;
        for (int k = 0; k < n; k++) begin
            if ($urandom_range(0, 9) == 0) add_tick(d, 17'($urandom_range(0, 86399)), rnd_px());
            else begin
                if ($urandom_range(0, 3) == 0) t = next_slot_guess(t);
                else t = t + $urandom_range(0, 2 * iv_reg + 1);
                if (t > 86399) t = 86399;
                add_tick(d, 17'(t), rnd_px());
            end
        end
    endfunction

    initial begin
        logic [15:0] d;
        iv_reg = INTERVAL_RST; open_reg = OPEN_RST; close_reg = CLOSE_RST;
        cur_day = '0; day_seen = 1'b0; next_slot = '0; last_tick = '0;
        last_px = '0; day_done = 1'b1;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: new day before open, open, exact, mix, zero weight, keep,
        // ignored, after close twice, extremes of the fields
        add_tick(16'd0, 17'd100, 48'd5);
        add_tick(16'd0, 17'd34300, 48'd7);
        add_tick(16'd1, 17'd34200, 48'h10000);
        add_tick(16'd1, 17'd34500, PMAX);
        add_tick(16'd1, 17'd34600, 48'd1);
        add_tick(16'd1, 17'd34700, 48'd9);
        add_tick(16'd1, 17'd35000, PMAX);
        add_tick(16'd1, 17'd35000, 48'd0);
        add_tick(16'd1, 17'd34200, 48'd3);
        add_tick(16'd1, 17'd40000, 48'd0);
        add_tick(16'd1, 17'd57600, 48'h123456789ABC);
        add_tick(16'd1, 17'd60000, 48'd1);
        add_tick(16'd1, 17'd86399, 48'd1);
        add_tick(16'd1, 17'd50000, 48'd77);
        add_tick(16'hFFFF, 17'd86399, PMAX);
        add_tick(16'hFFFF, 17'd86399, 48'd0);
        add_tick(16'd2, 17'd0, 48'd0);
        add_tick(16'h5555, 17'h0AAAA, 48'hAAAA_AAAA_AAAA);
        add_tick(16'hAAAA, 17'h15555, 48'h5555_5555_5555);
        wait_drained();

        // directed: mix with a late slot, tick before the last tick
        write_reg(CFG_INTERVAL, 17'd1000);
        write_reg(CFG_OPEN, 17'd0);
        write_reg(CFG_CLOSE, 17'd86399);
        add_tick(16'd3, 17'd500, 48'd100);
        add_tick(16'd3, 17'd900, 48'd200);
        add_tick(16'd3, 17'd600, 48'd50);
        add_tick(16'd3, 17'd2500, PMAX);
        add_tick(16'd4, 17'd0, 48'd1);
        wait_drained();

        // random phases over several settings
        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                0: begin write_reg(CFG_INTERVAL, 17'd300); write_reg(CFG_OPEN, 17'd34200);
                         write_reg(CFG_CLOSE, 17'd57600); end
                1: begin write_reg(CFG_INTERVAL, 17'd0); write_reg(CFG_OPEN, 17'd100);
                         write_reg(CFG_CLOSE, 17'd160); end
                2: begin write_reg(CFG_INTERVAL, 17'd86399); write_reg(CFG_OPEN, 17'd0);
                         write_reg(CFG_CLOSE, 17'd86399); end
                3: begin write_reg(CFG_INTERVAL, 17'd7); write_reg(CFG_OPEN, 17'd50000);
                         write_reg(CFG_CLOSE, 17'd40000); end
                4: begin write_reg(CFG_INTERVAL, 17'd1); write_reg(CFG_OPEN, 17'd86399);
                         write_reg(CFG_CLOSE, 17'd86399); end
                default: begin write_reg(CFG_INTERVAL, 17'($urandom_range(20, 90)));
                         write_reg(CFG_OPEN, 17'($urandom_range(1000, 2000)));
                         write_reg(CFG_CLOSE, 17'($urandom_range(2500, 4000))); quiet = 1'b1; end
            endcase
            d = 16'($urandom_range(10, 60000));
            for (int k = 0; k < 4; k++) begin
                add_day(d, $urandom_range(4, 10));
                d = d + 16'($urandom_range(1, 3));
            end
            wait_drained();
        end

        $display("covered %0d ticks and %0d output words over eight register settings",
                 n_ticks, n_words);
        if (n_fail == 0) $display("RESULT: OK");
        else $display("RESULT: ERROR");
        $finish;
    end

    initial begin
        #20ms;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
